FILE: hdl/char_lcd_refresh_nibble_writer_unit_macros.svh
// Assertion macros shared by the character LCD refresh writer modules.
// No dependencies; each file that asserts includes this header.
`ifndef CHAR_LCD_REFRESH_NIBBLE_WRITER_UNIT_MACROS_SVH
`define CHAR_LCD_REFRESH_NIBBLE_WRITER_UNIT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define CLNW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define CLNW_ASSERT_IMP(label, cond, cons, msg) \
  `CLNW_ASSERT(label, (cond) |-> (cons), msg)

`endif

FILE: hdl/clnw_pkg.sv
// Package for the character LCD refresh writer: types, codes, tables.
// Used by the top level, controller and datapath; depends on nothing.
package clnw_pkg;

  // Default screen geometry.
  localparam int ROWS_DEF = 4;
  localparam int COLS_DEF = 20;

  // Fixed field widths.
  localparam int ROW_W  = 2;
  localparam int COL_W  = 5;
  localparam int CHAR_W = 8;
  localparam int BYTE_W = 8;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_EXPANDER_ADDR = 1'b0;

  // Index of the last set-up command in the init sequence.
  localparam logic [2:0] INIT_LAST = 3'd4;

  // Set DDRAM address (cursor) command code.
  localparam logic [7:0] CURSOR_CMD = 8'h80;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_START = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_INIT  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SEND
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_write;
    logic do_start;
    logic do_tick;
    logic do_init;
    logic fetch_load;
    logic emit;
    logic next_byte;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic screen_ready;
    logic out_free;
    logic phase_last;
    logic init_more;
  } status_t;

  // DDRAM base address of each display row.
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    unique case (row)
      2'd0: base = 8'h00;
      2'd1: base = 8'h40;
      2'd2: base = 8'h14;
      2'd3: base = 8'h54;
      default: base = 8'h00;
    endcase
    return base;
  endfunction

  // The display set-up commands in the order they are sent.
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] cmd;
    unique case (idx)
      3'd0: cmd = 8'h02;
      3'd1: cmd = 8'h28;
      3'd2: cmd = 8'h0C;
      3'd3: cmd = 8'h06;
      3'd4: cmd = 8'h01;
      default: cmd = 8'h00;
    endcase
    return cmd;
  endfunction

endpackage

FILE: hdl/char_lcd_refresh_nibble_writer_unit.sv
// Top level of the character LCD refresh writer: stream ports, APB register.
// Depends on clnw_pkg, clnw_ctrl, clnw_datapath and clnw_ram.
//
// Keeps a ROWS x COLS screen buffer for an HD44780 display behind an 8-bit
// port expander and turns each display byte into four expander port writes
// (high nibble with E set and cleared, then low nibble the same way).
// A character write, a refresh start or a tick on a finished screen is done
// on acceptance. A refresh tick is accepted in the idle state, the registered
// screen buffer RAM read follows in the fetch state, then the four port
// writes go out, each held while the result side stalls. The init request
// sends its 20 port writes. The nibble sequencer sets the rate: one port
// write per cycle into a single output register while it is free. The buffer
// reads as all zeros after reset through one valid bit per entry; there is
// no clearing pass. The expander address register sits at byte address 0 and
// must be written only while the block idles; the block does not enforce it.
module char_lcd_refresh_nibble_writer_unit #(
  parameter int ROWS = clnw_pkg::ROWS_DEF,
  parameter int COLS = clnw_pkg::COLS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: row[1:0], column[6:2], character[14:7], zero [15].
  input  logic [15:0]                   s_axis_tdata,
  // Fields from bit 0: mode[1:0].
  input  logic [1:0]                    s_axis_tuser,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: device_address[7:0], port_byte[15:8].
  output logic [15:0]                   m_axis_tdata,
  output logic                          m_axis_tlast,
  // Fields from bit 0: refresh_done[0].
  output logic                          m_axis_tuser,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clnw_pkg::PADDR_W-1:0]  paddr,
  input  logic [clnw_pkg::PDATA_W-1:0]  pwdata,
  output logic [clnw_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  clnw_pkg::cmd_t    cmd;
  clnw_pkg::status_t status;
  logic              cfg_we;
  logic [7:0]        expander_address;
  logic [7:0]        device_address, port_byte;

  // Register access: word index is paddr[2].
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == clnw_pkg::REG_EXPANDER_ADDR);
  assign prdata = (paddr[2] == clnw_pkg::REG_EXPANDER_ADDR) ?
                  {{(clnw_pkg::PDATA_W-8){1'b0}}, expander_address} : '0;

  clnw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .mode_i     (clnw_pkg::mode_e'(s_axis_tuser)),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  clnw_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .row_i              (s_axis_tdata[1:0]),
    .column_i           (s_axis_tdata[6:2]),
    .character_i        (s_axis_tdata[14:7]),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (pwdata[7:0]),
    .expander_address_o (expander_address),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .device_address_o   (device_address),
    .port_byte_o        (port_byte),
    .last_of_run_o      (m_axis_tlast),
    .refresh_done_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {port_byte, device_address};

endmodule

FILE: hdl/clnw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module clnw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/clnw_datapath.sv
// Datapath of the LCD refresh writer: screen buffer, refresh position,
// byte-to-nibble expansion and the output register. Uses clnw_pkg, clnw_ram.
`include "char_lcd_refresh_nibble_writer_unit_macros.svh"

module clnw_datapath #(
  parameter int ROWS = clnw_pkg::ROWS_DEF,
  parameter int COLS = clnw_pkg::COLS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  clnw_pkg::cmd_t               cmd_i,
  output clnw_pkg::status_t            status_o,
  // Request fields.
  input  logic [clnw_pkg::ROW_W-1:0]   row_i,
  input  logic [clnw_pkg::COL_W-1:0]   column_i,
  input  logic [clnw_pkg::CHAR_W-1:0]  character_i,
  // Configuration.
  input  logic                         cfg_we_i,
  input  logic [7:0]                   cfg_wdata_i,
  output logic [7:0]                   expander_address_o,
  // Result register.
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [7:0]                   device_address_o,
  output logic [7:0]                   port_byte_o,
  output logic                         last_of_run_o,
  output logic                         refresh_done_o
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [2:0] ROW_LIM = 3'(ROWS);
  localparam logic [clnw_pkg::COL_W-1:0] COL_LIM = clnw_pkg::COL_W'(COLS);

  logic [7:0]                  expander_q;
  logic [clnw_pkg::ROW_W-1:0]  row_q, row_d;
  logic [clnw_pkg::COL_W-1:0]  col_q, col_d;
  logic                        ready_q, ready_d;
  logic [DEPTH-1:0]            valid_q;
  logic                        valid_rd_q;
  logic [7:0]                  byte_q;
  logic                        rs_q;
  logic                        init_q;
  logic [2:0]                  init_idx_q;
  logic [1:0]                  phase_q;
  logic                        out_valid_q;
  logic [7:0]                  out_addr_q, out_port_q;
  logic                        out_last_q, out_done_q;

  logic [clnw_pkg::ROW_W-1:0]  row_n;
  logic [clnw_pkg::COL_W-1:0]  col_n, col_nx;
  logic [2:0]                  row_nx;
  logic                        wr_hit;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [7:0]                  ram_rdata;
  logic [3:0]                  nibble;
  logic [7:0]                  port_val;
  logic                        last_val;

  // Screen write decode.
  assign wr_hit  = cmd_i.do_write && ({1'b0, row_i} < ROW_LIM) && (column_i < COL_LIM);
  assign wr_addr = AW'(AW'(row_i) * AW'(COLS)) + AW'(column_i);

  // Refresh position, brought back into range before use.
  assign row_n  = ({1'b0, row_q} >= ROW_LIM) ? '0 : row_q;
  assign col_n  = (col_q > COL_LIM) ? '0 : col_q;
  assign col_nx = col_n + 1'b1;
  assign row_nx = {1'b0, row_n} + 3'd1;
  assign rd_addr = AW'(AW'(row_n) * AW'(COLS)) + AW'(col_n - 1'b1);

  // Next refresh position after a tick, or a restart.
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    ready_d = ready_q;
    if (cmd_i.do_start) begin
      row_d   = '0;
      col_d   = '0;
      ready_d = 1'b0;
    end else if (cmd_i.do_tick) begin
      row_d = row_n;
      col_d = col_nx;
      if (col_nx > COL_LIM) begin
        col_d = '0;
        if (row_nx >= ROW_LIM) begin
          row_d   = '0;
          ready_d = 1'b1;
        end else begin
          row_d = row_nx[clnw_pkg::ROW_W-1:0];
        end
      end
    end
  end

  // Control registers: configuration, refresh state, valid bits, output flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expander_q  <= '0;
      row_q       <= '0;
      col_q       <= '0;
      ready_q     <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        expander_q <= cfg_wdata_i;
      end
      row_q   <= row_d;
      col_q   <= col_d;
      ready_q <= ready_d;
      if (wr_hit) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Screen buffer.
  clnw_ram #(
    .WIDTH (clnw_pkg::CHAR_W),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (wr_hit),
    .waddr_i (wr_addr),
    .wdata_i (character_i),
    .re_i    (cmd_i.do_tick),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Nibble selection: high nibble in the first two phases, E in even phases.
  assign nibble   = phase_q[1] ? byte_q[3:0] : byte_q[7:4];
  assign port_val = {nibble, 1'b1, ~phase_q[0], 1'b0, rs_q};
  assign last_val = (phase_q == 2'd3) && !(init_q && (init_idx_q != clnw_pkg::INIT_LAST));

  // Byte under expansion and its phase counter.
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_tick) begin
      valid_rd_q <= valid_q[rd_addr];
      byte_q     <= clnw_pkg::CURSOR_CMD | clnw_pkg::row_base(row_n);
      rs_q       <= (col_n != '0);
      init_q     <= 1'b0;
      phase_q    <= '0;
    end else if (cmd_i.do_init) begin
      byte_q     <= clnw_pkg::init_cmd(3'd0);
      rs_q       <= 1'b0;
      init_q     <= 1'b1;
      init_idx_q <= '0;
      phase_q    <= '0;
    end else begin
      // A never-written entry reads as the cleared value.
      if (cmd_i.fetch_load && rs_q) begin
        byte_q <= valid_rd_q ? ram_rdata : '0;
      end
      if (cmd_i.next_byte) begin
        init_idx_q <= init_idx_q + 3'd1;
        byte_q     <= clnw_pkg::init_cmd(init_idx_q + 3'd1);
      end
      if (cmd_i.emit) begin
        phase_q <= phase_q + 2'd1;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_addr_q <= expander_q;
      out_port_q <= port_val;
      out_last_q <= last_val;
      out_done_q <= ready_q;
    end
  end

  assign status_o.screen_ready = ready_q;
  assign status_o.out_free     = !out_valid_q || out_ready_i;
  assign status_o.phase_last   = (phase_q == 2'd3);
  assign status_o.init_more    = init_q && (init_idx_q != clnw_pkg::INIT_LAST);

  assign expander_address_o = expander_q;
  assign out_valid_o        = out_valid_q;
  assign device_address_o   = out_addr_q;
  assign port_byte_o        = out_port_q;
  assign last_of_run_o      = out_last_q;
  assign refresh_done_o     = out_done_q;

  // A new port write never overwrites one that is still waiting.
  `CLNW_ASSERT_IMP(a_no_overwrite, cmd_i.emit, !out_valid_q || out_ready_i, "result overwritten")
  // The last write of a request always has E low.
  `CLNW_ASSERT_IMP(a_last_e_low, out_valid_q && out_last_q, !out_port_q[2], "last write with E")
  // The refresh position stays on the screen.
  `CLNW_ASSERT(a_pos_range, (col_q <= COL_LIM) && ({1'b0, row_q} < ROW_LIM), "position off screen")

endmodule

FILE: hdl/clnw_ctrl.sv
// Controller of the LCD refresh writer: request decode and byte sequencing.
// Uses clnw_pkg; drives the datapath through cmd_t and reads status_t.
`include "char_lcd_refresh_nibble_writer_unit_macros.svh"

module clnw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  clnw_pkg::mode_e   mode_i,
  output logic              in_ready_o,
  input  clnw_pkg::status_t status_i,
  output clnw_pkg::cmd_t    cmd_o
);

  clnw_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clnw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands. In the idle state the request side is always ready,
  // so a valid request there is an accepted one.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      clnw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (mode_i)
            clnw_pkg::MODE_WRITE: cmd_o.do_write = 1'b1;
            clnw_pkg::MODE_START: cmd_o.do_start = 1'b1;
            clnw_pkg::MODE_TICK: begin
              // A tick on a finished screen does nothing.
              if (!status_i.screen_ready) begin
                cmd_o.do_tick = 1'b1;
                state_d       = clnw_pkg::ST_FETCH;
              end
            end
            clnw_pkg::MODE_INIT: begin
              cmd_o.do_init = 1'b1;
              state_d       = clnw_pkg::ST_SEND;
            end
            default: ;
          endcase
        end
      end
      clnw_pkg::ST_FETCH: begin
        cmd_o.fetch_load = 1'b1;
        state_d          = clnw_pkg::ST_SEND;
      end
      clnw_pkg::ST_SEND: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.phase_last) begin
            if (status_i.init_more) begin
              cmd_o.next_byte = 1'b1;
            end else begin
              state_d = clnw_pkg::ST_IDLE;
            end
          end
        end
      end
      default: state_d = clnw_pkg::ST_IDLE;
    endcase
  end

  // A buffer read always comes right after an accepted tick.
  `CLNW_ASSERT_IMP(a_fetch_after_tick, state_q == clnw_pkg::ST_FETCH, $past(cmd_o.do_tick), "fetch without tick")
  // Nothing is emitted while requests are being taken.
  `CLNW_ASSERT_IMP(a_no_emit_idle, in_ready_o, !cmd_o.emit, "emit while idle")

endmodule
